// ===== src/css_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the case-folding function of the caseless substring search unit.
package css_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_REG_W   = 5;
    localparam int POS_W       = 16;

    // Reset value of the start limit before it is cut to the offset width.
    localparam logic [31:0] LIMIT_RESET_VAL = 32'd65535;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_START_LIMIT  = 2'd3
    } cfg_reg_t;

    // Letters A to Z and the Latin-1 capitals (bar the multiplication sign) fold to lower case.
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic upper;
        upper = (b inside {[8'h41:8'h5A]}) || ((b inside {[8'hC0:8'hDE]}) && (b != 8'hD7));
        return upper ? (b + 8'h20) : b;
    endfunction

endpackage

// ===== src/caseless_substring_search_unit.sv =====
`timescale 1ns / 1ps
// Top level of the caseless substring search unit: input register, window compare, result register.
//
//  Channel   Signals                                 Direction  Accepted when
//  ------    -------------------------------------   ---------  ---------------------------
//  config    cfg_we, cfg_index, cfg_data             in         cfg_we high
//  text in   in_valid, in_stall, text_byte/first/last in         in_valid high, in_stall low
//  result    out_valid, out_stall, found/match_pos    out        out_valid high, out_stall low
//
// One text word is taken every cycle while in_stall is low. A word is held in the input
// register, where the window compare and the end checks run against the stored recent bytes,
// and any result is loaded into the output register when the word moves on. The window
// compare between those two registers sets the rate.
// Reset is asynchronous and active low; it restores the register reset values and clears
// the search state as if a new text began. While a result waits under out_stall, one more
// word may sit in the input register; only then is in_stall raised.
module caseless_substring_search_unit
    import css_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 16
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      text_byte,
    input  logic                   first,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [POS_W-1:0]       match_pos
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = OFFSET_BITS + 1;
    localparam int CMP_W = OFFSET_BITS + 2;
    localparam logic [CNT_W-1:0]       CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [OFFSET_BITS-1:0] LIMIT_RESET = OFFSET_BITS'(LIMIT_RESET_VAL);

    // Configuration registers.
    logic [CFG_DATA_W-1:0]  pattern_low_reg;
    logic [CFG_DATA_W-1:0]  pattern_high_reg;
    logic [LEN_REG_W-1:0]   pattern_len_reg;
    logic [OFFSET_BITS-1:0] start_limit_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] text_reg;
    logic              first_reg;
    logic              last_reg;

    // Search state.
    logic [BYTE_W-1:0] recent_reg [MAX_PATTERN];
    logic [CNT_W-1:0]  offset_reg;
    logic              done_reg;

    // Result register.
    logic             res_valid_reg;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;

    logic slot_free;
    logic advance;
    logic in_accept;

    logic [BYTE_W*PAT_BYTES-1:0] pat_vec;
    logic [LEN_REG_W-1:0]        len_clip;
    logic [LEN_W-1:0]            eff_len;
    logic [BYTE_W-1:0]           pat_fold [MAX_PATTERN];

    logic [BYTE_W-1:0] recent_next [MAX_PATTERN];
    logic [CNT_W-1:0]  cur_offset;
    logic              cur_done;
    logic [CNT_W-1:0]  offset_next;
    logic              hit;
    logic [LEN_W-1:0]  k_idx;
    logic [CMP_W-1:0]  t1;
    logic [CMP_W-1:0]  len_c;
    logic [CMP_W-1:0]  limit_c;
    logic [CMP_W-1:0]  start;
    logic              window_ok;
    logic              in_range;
    logic              text_end;
    logic              produce;
    logic              found_next;
    logic [POS_W-1:0]  pos_next;

    // The result slot is free when empty or when its word leaves at this edge.
    assign slot_free = !res_valid_reg || !out_stall;
    assign advance   = in_valid_reg && slot_free;
    assign in_stall  = in_valid_reg && !slot_free;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = res_valid_reg;
    assign found     = found_reg;
    assign match_pos = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= '0;
            start_limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_REG_W-1:0];
                REG_START_LIMIT:  start_limit_reg  <= cfg_data[OFFSET_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Effective pattern length: the register value, clipped to the pattern store, and cut
    // short at the first zero byte inside it.
    assign pat_vec = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_len_reg > LEN_REG_W'(MAX_PATTERN))
            len_clip = LEN_REG_W'(MAX_PATTERN);
        else
            len_clip = pattern_len_reg;
        eff_len = LEN_W'(len_clip);
        for (int k = MAX_PATTERN - 1; k >= 0; k--)
        begin
            if ((LEN_REG_W'(k) < len_clip) && (pat_vec[BYTE_W*k +: BYTE_W] == '0))
                eff_len = LEN_W'(k);
        end
        for (int k = 0; k < MAX_PATTERN; k++)
            pat_fold[k] = fold_case(pat_vec[BYTE_W*k +: BYTE_W]);
    end

    // Window compare and end checks for the word in the input register. A first flag
    // behaves as if the search state had been cleared just before this word.
    always_comb
    begin
        cur_offset = first_reg ? '0 : offset_reg;
        cur_done   = first_reg ? 1'b0 : done_reg;

        recent_next[0] = text_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
            recent_next[i] = first_reg ? '0 : recent_reg[i-1];

        offset_next = (cur_offset == CNT_MAX) ? cur_offset : cur_offset + 1'b1;

        // The newest byte sits at position 0 and lines up with the last pattern byte.
        hit   = 1'b1;
        k_idx = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (LEN_W'(j) < eff_len)
            begin
                k_idx = eff_len - LEN_W'(j) - 1'b1;
                if (fold_case(recent_next[j]) != pat_fold[k_idx[IDX_W-1:0]])
                    hit = 1'b0;
            end
        end

        t1        = CMP_W'(cur_offset) + 1'b1;
        len_c     = CMP_W'(eff_len);
        limit_c   = CMP_W'(start_limit_reg);
        start     = t1 - len_c;
        window_ok = t1 >= len_c;
        in_range  = start <= limit_c;
        text_end  = (text_reg == '0) || last_reg || (t1 >= limit_c + len_c);

        produce    = 1'b0;
        found_next = 1'b0;
        pos_next   = '0;
        if (!cur_done)
        begin
            if (eff_len == '0)
            begin
                // An empty pattern matches at the very start.
                produce    = 1'b1;
                found_next = 1'b1;
            end
            else if (window_ok && in_range && hit)
            begin
                // A match wins over any end condition raised by the same byte.
                produce    = 1'b1;
                found_next = 1'b1;
                pos_next   = POS_W'(start[OFFSET_BITS-1:0]);
            end
            else if (text_end)
            begin
                produce = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            text_reg      <= '0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++)
                recent_reg[i] <= '0;
            offset_reg    <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
                text_reg     <= text_byte;
                first_reg    <= first;
                last_reg     <= last;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // Once a result has been given, words are ignored until the next first flag.
            if (advance && !cur_done)
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                    recent_reg[i] <= recent_next[i];
                offset_reg <= offset_next;
                done_reg   <= produce;
            end

            if (advance && produce)
            begin
                res_valid_reg <= 1'b1;
                found_reg     <= found_next;
                pos_reg       <= pos_next;
            end
            else if (res_valid_reg && !out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/css_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the caseless substring search unit, with its bind statement.
module css_checker
    import css_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             found,
    input logic [POS_W-1:0] match_pos
);

    // A waiting result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_pos))
    else $error("result word changed while stalled");

    // A search that ends without a match reports offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_pos == '0)
    else $error("not-found result carries a non-zero offset");

    // The input side is held back only while a result word is stuck at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output is free");

    // A new result word follows an accepted word through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without a matching input word");

endmodule

bind caseless_substring_search_unit css_checker u_css_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .match_pos (match_pos)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the caseless substring search unit, with its match scoreboard.

// Tracks the search state of the unit, works out the result that each accepted text word
// causes, and checks the results that the unit gives against them in order.
class match_tracker;

    typedef struct {
        logic                       found;
        logic [css_pkg::POS_W-1:0]  pos;
    } search_result_t;

    search_result_t  awaited[$];
    logic [63:0]     pat_lo;
    logic [63:0]     pat_hi;
    logic [4:0]      pat_len;
    logic [15:0]     limit;
    logic [7:0]      window [16];
    logic [16:0]     offset;
    bit              done;
    int              errors;

    function new();
        pat_lo  = '0;
        pat_hi  = '0;
        pat_len = '0;
        limit   = 16'hFFFF;
        errors  = 0;
        clear_search();
    endfunction

    function void clear_search();
        foreach (window[i])
            window[i] = 8'h00;
        offset = '0;
        done   = 1'b0;
    endfunction

    function void set_reg(css_pkg::cfg_reg_t idx, logic [63:0] d);
        case (idx)
            css_pkg::REG_PATTERN_LOW:  pat_lo  = d;
            css_pkg::REG_PATTERN_HIGH: pat_hi  = d;
            css_pkg::REG_PATTERN_LEN:  pat_len = d[4:0];
            css_pkg::REG_START_LIMIT:  limit   = d[15:0];
            default: ;
        endcase
    endfunction

    function logic [7:0] lower(logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDE && b != 8'hD7))
            return b + 8'h20;
        return b;
    endfunction

    function logic [7:0] pat_byte(int k);
        return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
    endfunction

    // Lengths above sixteen are clipped, and a zero byte cuts the pattern short.
    function int used_length();
        int n;
        n = (pat_len > 5'd16) ? 16 : int'(pat_len);
        for (int k = 0; k < n; k++)
            if (pat_byte(k) == 8'h00)
                return k;
        return n;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void await_result(logic f, logic [css_pkg::POS_W-1:0] p);
        search_result_t r;
        r.found = f;
        r.pos   = p;
        awaited.push_back(r);
    endfunction

    // Notes one accepted word. Returns 0 when the unit is bound to ignore it.
    function bit take_word(logic [7:0] b, logic f, logic l);
        int  t;
        int  n;
        int  start;
        bit  hit;
        if (f)
            clear_search();
        if (done)
            return 1'b0;
        t = int'(offset);
        for (int k = 15; k > 0; k--)
            window[k] = window[k-1];
        window[0] = b;
        if (offset != 17'h1FFFF)
            offset = offset + 17'd1;
        n = used_length();
        if (n == 0)
        begin
            done = 1'b1;
            await_result(1'b1, '0);
            return 1'b1;
        end
        if (t + 1 >= n)
        begin
            start = t + 1 - n;
            if (start <= int'(limit))
            begin
                hit = 1'b1;
                for (int k = 0; k < n; k++)
                    if (lower(pat_byte(k)) != lower(window[n-1-k]))
                        hit = 1'b0;
                if (hit)
                begin
                    done = 1'b1;
                    await_result(1'b1, start[15:0]);
                    return 1'b1;
                end
            end
        end
        if (b == 8'h00 || l || t + 1 >= int'(limit) + n)
        begin
            done = 1'b1;
            await_result(1'b0, '0);
        end
        return 1'b1;
    endfunction

    function void check_result(logic f, logic [css_pkg::POS_W-1:0] p);
        search_result_t r;
        if (awaited.size() == 0)
        begin
            $error("unexpected result: found=%0d match_pos=%0d", f, p);
            errors++;
            return;
        end
        r = awaited.pop_front();
        if (f !== r.found)
        begin
            $error("found: expected %0d, actual %0d", r.found, f);
            errors++;
        end
        if (p !== r.pos)
        begin
            $error("match_pos: expected %0d, actual %0d", r.pos, p);
            errors++;
        end
    endfunction

endclass

module tb_top;

    import css_pkg::*;

    localparam int TEXT_WORDS  = 1450;
    localparam int CYCLE_LIMIT = 200000;
    // Idle cycles waited after the last result, with a margin for words that cause no result.
    localparam int SETTLE      = 6;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      text_byte = '0;
    logic                   first     = 1'b0;
    logic                   last      = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   found;
    logic [POS_W-1:0]       match_pos;

    match_tracker tracker = new();
    int           live_words = 0;
    int           cycles     = 0;
    // While calm is set neither side idles at random, so the unit runs back to back between drains.
    bit           calm       = 1'b0;

    caseless_substring_search_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .first     (first),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .match_pos (match_pos)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: every accepted result is checked at the edge that takes it, using the
    // values from before that edge, and the stall for the next cycle is chosen at random unless calm is set.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(found, match_pos);
        out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    // A run that hangs is cut off here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] flip_case(logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDE && b != 8'hD7))
            return b + 8'h20;
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'hE0 && b <= 8'hFE && b != 8'hF7))
            return b - 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] maybe_flip(logic [7:0] b);
        return $urandom_range(0, 1) ? flip_case(b) : b;
    endfunction

    // Text bytes lean towards the pattern's own bytes and letters, so that near misses and
    // case-swapped matches turn up often; the rest is any non-zero byte.
    function automatic logic [7:0] text_pick();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = tracker.used_length();
        if (r < 45 && n > 0)
            return maybe_flip(tracker.pat_byte($urandom_range(0, n - 1)));
        if (r < 70)
            return maybe_flip(8'($urandom_range(8'h61, 8'h7A)));
        if (r < 80)
            return 8'($urandom_range(8'hC0, 8'hFF));
        return 8'($urandom_range(1, 255));
    endfunction

    // Pattern bytes: mostly letters of either case, some Latin-1, now and then a zero byte
    // that cuts the pattern short.
    function automatic logic [7:0] pattern_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 70)
            return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 82)
            return 8'($urandom_range(8'hC0, 8'hFE));
        if (r < 97)
            return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    // Offers one word and holds it until it is taken, idling at random beforehand.
    task automatic send_word(logic [7:0] b, logic f, logic l);
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        first     <= f;
        last      <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(tracker.take_word(b, f, l));
        live_words++;
    endtask

    // Holds the sender back until every awaited result has come, then lets the pipeline
    // empty of words that cause no result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [63:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        tracker.set_reg(idx, d);
    endtask

    task automatic write_regs(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                              logic [15:0] lim);
        drain_results();
        put_reg(REG_PATTERN_LOW, lo);
        put_reg(REG_PATTERN_HIGH, hi);
        put_reg(REG_PATTERN_LEN, {59'd0, len});
        put_reg(REG_START_LIMIT, {48'd0, lim});
        cfg_we <= 1'b0;
    endtask

    // Every few phases a setting is forced to an extreme: the longest pattern with the
    // widest limit, or a clipped length with a limit of zero.
    task automatic random_setting(int phase);
        logic [63:0] w [2];
        logic [4:0]  len;
        logic [15:0] lim;
        int          r;
        for (int i = 0; i < 2; i++)
        begin
            for (int k = 0; k < 8; k++)
                w[i][8*k +: 8] = pattern_pick();
            if ($urandom_range(0, 9) == 0)
                w[i] = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < 8)
            len = 5'd0;
        else if (r < 20)
            len = 5'd16;
        else if (r < 28)
            len = 5'($urandom_range(17, 31));
        else
            len = 5'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 25)
            lim = 16'hFFFF;
        else if (r < 40)
            lim = 16'h0000;
        else if (r < 45)
            lim = 16'($urandom_range(0, 65535));
        else
            lim = 16'($urandom_range(1, 30));
        if (phase % 7 == 0)
        begin
            len = 5'd16;
            lim = 16'hFFFF;
        end
        else if (phase % 7 == 3)
        begin
            len = 5'd31;
            lim = 16'h0000;
        end
        write_regs(w[0], w[1], len, lim);
    endtask

    // One text: random lead-in, then usually the pattern with its case shuffled, sometimes
    // only part of it, then a random tail. Some texts carry a stray NUL, some lack the first
    // or the last mark, and some are followed by stray words without a first mark.
    task automatic send_text();
        logic [7:0] body [$];
        int         n;
        int         r;
        bit         mark_first;
        bit         mark_last;
        n = tracker.used_length();
        repeat ($urandom_range(0, 10)) body.push_back(text_pick());
        r = $urandom_range(0, 99);
        if (n > 0 && r < 65)
        begin
            for (int k = 0; k < n; k++)
                body.push_back(maybe_flip(tracker.pat_byte(k)));
        end
        else if (n > 1 && r < 80)
        begin
            for (int k = 0; k < n - 1; k++)
                body.push_back(maybe_flip(tracker.pat_byte(k)));
        end
        repeat ($urandom_range(0, 5)) body.push_back(text_pick());
        if (body.size() == 0)
            body.push_back(text_pick());
        if ($urandom_range(0, 99) < 6)
            body[$urandom_range(0, body.size() - 1)] = 8'h00;
        mark_first = $urandom_range(0, 99) < 92;
        mark_last  = $urandom_range(0, 99) < 80;
        foreach (body[i])
            send_word(body[i], mark_first && i == 0, mark_last && i == body.size() - 1);
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                send_word(text_pick(), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset setting the pattern is empty: the very first word matches at
        // offset 0 even though it is a NUL and carries no first mark, and the word after
        // the result is ignored.
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);

        // Pattern "AbC": a case-blind match completed by the last word still counts,
        // then a NUL and a last mark each end a text without a match.
        write_regs(64'h0000_0000_0043_6241, 64'h0, 5'd3, 16'hFFFF);
        send_word("x", 1'b1, 1'b0);
        send_word("a", 1'b0, 1'b0);
        send_word("B", 1'b0, 1'b0);
        send_word("c", 1'b0, 1'b1);
        send_word("a", 1'b1, 1'b0);
        send_word("b", 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word("z", 1'b1, 1'b0);
        send_word("z", 1'b0, 1'b1);

        // A length above sixteen, cut to three by the zero in byte 3. Latin-1 capitals fold,
        // the multiplication sign does not fold to the division sign.
        write_regs(64'hFFFF_FFFF_005A_D7C0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 16'hFFFF);
        send_word(8'hE0, 1'b1, 1'b0);
        send_word(8'hD7, 1'b0, 1'b0);
        send_word("z", 1'b0, 1'b1);
        send_word(8'hE0, 1'b1, 1'b0);
        send_word(8'hF7, 1'b0, 1'b0);
        send_word("z", 1'b0, 1'b1);

        // Limit of one with "ab": a match that starts right at the limit wins over the end of
        // the search on the same word; one offset later it is too late.
        write_regs(64'h0000_0000_0000_6261, 64'h0, 5'd2, 16'd1);
        send_word("x", 1'b1, 1'b0);
        send_word("A", 1'b0, 1'b0);
        send_word("B", 1'b0, 1'b0);
        send_word("x", 1'b1, 1'b0);
        send_word("x", 1'b0, 1'b0);
        send_word("a", 1'b0, 1'b0);
        send_word("b", 1'b0, 1'b0);

        // Random phases, each under a fresh setting written while the unit is idle.
        phase = 0;
        while (live_words < TEXT_WORDS)
        begin
            random_setting(phase);
            repeat ($urandom_range(6, 16))
            begin
                calm = (live_words >= 500 && live_words < 800);
                if ($urandom_range(0, 99) < 5)
                    drain_results();
                send_text();
            end
            phase++;
        end

        calm = 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
